/* design/scba_pkg.sv */
// Shared types, constants and helper functions for the size-class block allocator.
package scba_pkg;

   localparam int ChunkBytes   = 16384;
   localparam int MaxChunks    = 64;
   localparam int MaxSmallSize = 640;
   localparam int NumClasses   = 14;

   localparam int PoolSpan   = 1048576;
   localparam int ChunkFit   = PoolSpan / ChunkBytes;
   localparam int ChunkLimit = (MaxChunks < ChunkFit) ? MaxChunks : ChunkFit;
   localparam int ChunkCntW  = $clog2(ChunkLimit + 1);
   localparam int ClassW     = 4;
   localparam int GranW      = 16;
   localparam int LinkW      = 17;
   localparam int LinkDepth  = 65536;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NULL  = 2'd1;
   localparam logic [1:0] ST_BIG   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] request_size;
      logic [19:0] block_address;
      logic        address_is_null;
   } req_type;

   typedef struct packed {
      logic [19:0] result_address;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_ALLOC,
      KIND_FREE,
      KIND_CLEAR
   } kind_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      kind_type          kind;
      logic [1:0]        status;
      logic [ClassW-1:0] cls;
      logic [GranW-1:0]  gran;
   } cmd_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_READ,
      BE_SEND
   } be_state_type;

   function automatic logic [9:0] class_size(input logic [ClassW-1:0] c);
      logic [9:0] s;
      unique case (c)
         4'd0:  s = 10'd16;
         4'd1:  s = 10'd32;
         4'd2:  s = 10'd64;
         4'd3:  s = 10'd96;
         4'd4:  s = 10'd128;
         4'd5:  s = 10'd160;
         4'd6:  s = 10'd192;
         4'd7:  s = 10'd224;
         4'd8:  s = 10'd256;
         4'd9:  s = 10'd320;
         4'd10: s = 10'd384;
         4'd11: s = 10'd448;
         4'd12: s = 10'd512;
         4'd13: s = 10'd640;
         default: s = 10'd0;
      endcase
      return s;
   endfunction

   // Granules of one chunk that are covered by whole blocks of the class.
   function automatic logic [GranW:0] class_span(input logic [ClassW-1:0] c);
      logic [GranW:0] s;
      unique case (c)
         4'd0:  s = (GranW+1)'(ChunkBytes / 16 * 16 / 16);
         4'd1:  s = (GranW+1)'(ChunkBytes / 32 * 32 / 16);
         4'd2:  s = (GranW+1)'(ChunkBytes / 64 * 64 / 16);
         4'd3:  s = (GranW+1)'(ChunkBytes / 96 * 96 / 16);
         4'd4:  s = (GranW+1)'(ChunkBytes / 128 * 128 / 16);
         4'd5:  s = (GranW+1)'(ChunkBytes / 160 * 160 / 16);
         4'd6:  s = (GranW+1)'(ChunkBytes / 192 * 192 / 16);
         4'd7:  s = (GranW+1)'(ChunkBytes / 224 * 224 / 16);
         4'd8:  s = (GranW+1)'(ChunkBytes / 256 * 256 / 16);
         4'd9:  s = (GranW+1)'(ChunkBytes / 320 * 320 / 16);
         4'd10: s = (GranW+1)'(ChunkBytes / 384 * 384 / 16);
         4'd11: s = (GranW+1)'(ChunkBytes / 448 * 448 / 16);
         4'd12: s = (GranW+1)'(ChunkBytes / 512 * 512 / 16);
         4'd13: s = (GranW+1)'(ChunkBytes / 640 * 640 / 16);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

/* design/scba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module scba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* design/scba_front.sv */
// Front end: accepts requests, maps sizes to classes and queues classified commands.
module scba_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  scba_pkg::req_type   req_data,
   output logic                cmd_valid,
   input  logic                cmd_take,
   output scba_pkg::cmd_type   cmd_data
);
   import scba_pkg::*;

   localparam int QDepth = 2;

   cmd_type    q_ff [QDepth];
   cmd_type    q_in [QDepth];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls_cmd;
   logic       found;
   logic       push;

   always_comb begin
      cls_cmd = '0;
      found = 1'b0;
      for (int j = NumClasses - 1; j >= 0; j--) begin
         if ({2'b0, req_data.request_size} <= {4'b0, class_size(ClassW'(j))}) begin
            cls_cmd.cls = ClassW'(j);
            found = 1'b1;
         end
      end
      if (req_data.request_size > 12'(MaxSmallSize)) begin
         found = 1'b0;
      end
      cls_cmd.gran = req_data.block_address[19:4];
      cls_cmd.kind = KIND_DONE;
      cls_cmd.status = ST_NULL;
      priority if (req_data.opcode == OP_ALLOC) begin
         if (req_data.request_size == '0) begin
            cls_cmd.status = ST_NULL;
         end else if (!found) begin
            cls_cmd.status = ST_BIG;
         end else begin
            cls_cmd.kind = KIND_ALLOC;
         end
      end else if (req_data.opcode == OP_FREE) begin
         if (req_data.request_size == '0 || req_data.address_is_null) begin
            cls_cmd.status = ST_NULL;
         end else if (!found) begin
            cls_cmd.status = ST_BIG;
         end else begin
            cls_cmd.kind = KIND_FREE;
         end
      end else if (req_data.opcode == OP_CLEAR) begin
         cls_cmd.kind = KIND_CLEAR;
      end else begin
         cls_cmd.status = ST_NULL;
      end
   end

   assign req_stall = (cnt_ff == 2'(QDepth));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[0];

   always_comb begin
      logic       pop;
      logic [1:0] c;
      pop = cmd_valid && cmd_take;
      q_in = q_ff;
      c = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         c = c - 2'd1;
      end
      if (push) begin
         q_in[c[0]] = cls_cmd;
         c = c + 2'd1;
      end
      cnt_in = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

/* design/scba_back.sv */
// Back end: executes classified commands against the class heads and link memory.
module scba_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_take,
   input  scba_pkg::cmd_type   cmd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output scba_pkg::rsp_type   rsp_data
);
   import scba_pkg::*;

   be_state_type          state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   rsp_type               rsp_ff, rsp_in;
   logic [LinkW-1:0]      heads_ff [NumClasses];
   logic [LinkW-1:0]      heads_in [NumClasses];
   // Lazy carving: per class, the next uncarved granule and its end in the current chunk.
   logic [GranW:0]        carve_ff [NumClasses];
   logic [GranW:0]        carve_in [NumClasses];
   logic [GranW:0]        cend_ff  [NumClasses];
   logic [GranW:0]        cend_in  [NumClasses];
   logic [ChunkCntW-1:0]  used_ff, used_in;

   logic                  wr_en;
   logic [GranW-1:0]      wr_addr;
   logic [LinkW-1:0]      wr_data;
   logic [LinkW-1:0]      rd_data;

   scba_ram #(.Width(LinkW), .Depth(LinkDepth)) u_links (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (heads_ff[cmd_in.cls][GranW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd_data.kind == KIND_ALLOC) ? BE_READ : BE_SEND;
            end
         end
         BE_READ: state_in = BE_SEND;
         BE_SEND: if (!rsp_stall) state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      logic [GranW-1:0]     h;
      logic [9:0]           bs;
      logic [GranW:0]       bsg;
      logic [GranW:0]       nxt;
      logic [GranW+4:0]     base;
      cmd_take = (state_ff == BE_IDLE);
      cmd_in   = (state_ff == BE_IDLE && cmd_valid) ? cmd_data : cmd_ff;
      rsp_in   = rsp_ff;
      heads_in = heads_ff;
      carve_in = carve_ff;
      cend_in  = cend_ff;
      used_in  = used_ff;
      wr_en    = 1'b0;
      wr_addr  = cmd_ff.gran;
      wr_data  = heads_ff[cmd_ff.cls];
      h        = heads_ff[cmd_ff.cls][GranW-1:0];
      bs       = class_size(cmd_ff.cls);
      bsg      = (GranW+1)'(bs[9:4]);
      nxt      = carve_ff[cmd_ff.cls] + bsg;
      base     = (GranW+5)'(used_ff) * (GranW+5)'(ChunkBytes);
      unique case (state_ff)
         BE_IDLE: begin
            if (cmd_valid) begin
               rsp_in.result_address = '0;
               rsp_in.status = cmd_data.status;
               if (cmd_data.kind == KIND_FREE) begin
                  wr_en   = 1'b1;
                  wr_addr = cmd_data.gran;
                  wr_data = heads_ff[cmd_data.cls];
                  heads_in[cmd_data.cls] = {1'b1, cmd_data.gran};
                  rsp_in.status = ST_OK;
               end else if (cmd_data.kind == KIND_CLEAR) begin
                  for (int k = 0; k < NumClasses; k++) begin
                     heads_in[k] = '0;
                     carve_in[k] = '0;
                     cend_in[k]  = '0;
                  end
                  used_in = '0;
                  rsp_in.status = ST_OK;
               end
            end
         end
         BE_READ: begin
            if (heads_ff[cmd_ff.cls][GranW]) begin
               heads_in[cmd_ff.cls] = rd_data;
               rsp_in.result_address = {h, 4'b0};
               rsp_in.status = ST_OK;
            end else if (carve_ff[cmd_ff.cls] + bsg <= cend_ff[cmd_ff.cls]
                         && cend_ff[cmd_ff.cls] != '0) begin
               rsp_in.result_address = {carve_ff[cmd_ff.cls][GranW-1:0], 4'b0};
               rsp_in.status = ST_OK;
               carve_in[cmd_ff.cls] = nxt;
            end else if (32'(used_ff) >= 32'(ChunkLimit)) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.result_address = base[19:0];
               rsp_in.status = ST_OK;
               carve_in[cmd_ff.cls] = (GranW+1)'(base[GranW+4:4]) + bsg;
               cend_in[cmd_ff.cls]  = (GranW+1)'(base[GranW+4:4])
                  + class_span(cmd_ff.cls);
               used_in = used_ff + 1'b1;
            end
         end
         BE_SEND: ;
         default: ;
      endcase
   end

   assign rsp_valid = (state_ff == BE_SEND);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         used_ff  <= '0;
         for (int k = 0; k < NumClasses; k++) begin
            heads_ff[k] <= '0;
            carve_ff[k] <= '0;
            cend_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         heads_ff <= heads_in;
         carve_ff <= carve_in;
         cend_ff  <= cend_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end
endmodule

/* design/size_class_block_allocator_top.sv */
// Top level of the size-class block allocator.
// Requests arrive on the req_ channel as one beat each: allocate, free, clear or no-op.
// Every request yields exactly one beat on the rsp_ channel with an address and status.
// A front end classifies each request by size class and queues it two deep;
// a back end owns the class list heads and the 64K-entry link memory.
// Allocate passes the back end in order: a latch, the link memory read of the list
// head, then the response. Free, clear and rejected requests skip the read. The
// registered read port of the link memory is what adds the read step.
// Fresh chunks are carved lazily: a per-class cursor hands out blocks in address
// order once the class list is empty, so no linking walk is needed.
// Reset clears the class heads, the carve cursors and the chunk count at once;
// the link memory is not cleared and needs no sweep.
// When the receiver stalls, the response holds and the queue fills; req_stall
// rises once both queue entries are occupied.
module size_class_block_allocator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  scba_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output scba_pkg::rsp_type   rsp_data
);
   import scba_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   scba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   scba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

/* tb/scba_checker.sv */
// Checker for the size-class block allocator: predicts each response and compares it.
`timescale 1ns / 1ps

module scba_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  scba_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  scba_pkg::rsp_type rsp_data,
   output int                errors,
   output int                outstanding
);
   import scba_pkg::*;

   localparam int unsigned BlockBytes [14] = '{16, 32, 64, 96, 128, 160, 192, 224,
                                               256, 320, 384, 448, 512, 640};
   localparam logic [16:0] LinkLive = 17'h10000;

   logic [16:0] next_link [LinkDepth];
   logic [16:0] list_head [NumClasses];
   int unsigned chunks_taken;
   rsp_type     answer_q [$];

   initial begin
      foreach (next_link[i]) next_link[i] = '0;
      errors = 0;
      outstanding = 0;
   end

   // Smallest class holding the size, or -1 when none does.
   function automatic int class_for(input int unsigned size);
      if (size > MaxSmallSize) return -1;
      for (int j = 0; j < NumClasses; j++) begin
         if (size <= BlockBytes[j]) return j;
      end
      return -1;
   endfunction

   task automatic allocator_step(input req_type r, output rsp_type a);
      int          c;
      logic [3:0]  ci;
      int unsigned gran;
      int unsigned bs;
      int unsigned base;
      int unsigned addr;
      int unsigned count;
      a.result_address = '0;
      a.status = ST_NULL;
      c = class_for(r.request_size);
      ci = 4'(c);
      if (r.opcode == OP_ALLOC) begin
         if (r.request_size == 0) begin
            a.status = ST_NULL;
         end else if (c < 0) begin
            a.status = ST_BIG;
         end else if (list_head[ci][16]) begin
            gran = list_head[ci][15:0];
            list_head[ci] = next_link[16'(gran)];
            a.result_address = 20'(gran << 4);
            a.status = ST_OK;
         end else if (chunks_taken >= ChunkLimit) begin
            a.status = ST_EMPTY;
         end else begin
            // Carve the whole chunk into a list in address order.
            bs = BlockBytes[ci];
            base = chunks_taken * ChunkBytes;
            count = ChunkBytes / bs;
            for (int unsigned i = 0; i < count; i++) begin
               addr = base + i * bs;
               next_link[16'(addr >> 4)] =
                  (i + 1 < count) ? (LinkLive | 17'(((addr + bs) >> 4) & 16'hFFFF)) : '0;
            end
            list_head[ci] = next_link[16'(base >> 4)];
            chunks_taken++;
            a.result_address = 20'(base);
            a.status = ST_OK;
         end
      end else if (r.opcode == OP_FREE) begin
         if (r.request_size == 0 || r.address_is_null) begin
            a.status = ST_NULL;
         end else if (c < 0) begin
            a.status = ST_BIG;
         end else begin
            gran = r.block_address[19:4];
            next_link[16'(gran)] = list_head[ci];
            list_head[ci] = LinkLive | 17'(gran);
            a.status = ST_OK;
         end
      end else if (r.opcode == OP_CLEAR) begin
         foreach (list_head[i]) list_head[i] = '0;
         chunks_taken = 0;
         a.status = ST_OK;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (list_head[i]) list_head[i] = '0;
         chunks_taken = 0;
         answer_q.delete();
      end else begin
         // Compare first so a response can never match the request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: response beat with nothing expected: actual addr %h status %0d",
                        $time, rsp_data.result_address, rsp_data.status);
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.result_address !== want.result_address) begin
                  errors++;
                  $display("%0t: result_address expected %h actual %h", $time,
                           want.result_address, rsp_data.result_address);
               end
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            allocator_step(req_data, want);
            answer_q.push_back(want);
         end
      end
      outstanding = answer_q.size();
   end

endmodule

/* tb/tb_size_class_block_allocator_top.sv */
// Stimulus and verdict for the size-class block allocator testbench.
`timescale 1ns / 1ps

module tb_size_class_block_allocator_top;
   import scba_pkg::*;

   // The package names no code for the idle opcode, so it gets one here.
   localparam logic [1:0] OP_IDLE = 2'd3;
   localparam int CycleLimit = 1000000;

   typedef struct {
      logic [19:0] addr;
      logic [11:0] size;
   } held_block_type;

   typedef struct {
      bit          is_alloc;
      int          epoch;
      logic [11:0] size;
   } sent_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int errors;
   int outstanding;
   int cycles = 0;
   bit calm = 1'b0;

   // Blocks handed out since the last clear; frees are drawn from here.
   held_block_type held_q [$];
   sent_type       sent_q [$];
   int             epoch = 0;

   size_class_block_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   scba_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The watchdog ends a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Pair each response with the request that caused it and remember every block that an
   // allocate hands out. Answers to requests sent before the latest clear are dropped, since
   // freeing those blocks after a clear would scramble lists that a fresh carve later reuses.
   always @(posedge clock) begin
      sent_type s;
      if (!reset) begin
         if (rsp_valid && !rsp_stall && sent_q.size() != 0) begin
            s = sent_q.pop_front();
            if (s.is_alloc && s.epoch == epoch && rsp_data.status == ST_OK)
               held_q.push_back('{rsp_data.result_address, s.size});
         end
         if (req_valid && !req_stall)
            sent_q.push_back('{req_data.opcode == OP_ALLOC, epoch, req_data.request_size});
      end
   end

   // The receiver stalls for a random number of cycles before each beat, except in calm stretches.
   initial begin
      int w;
      @(negedge reset);
      forever begin
         w = calm ? 0 : $urandom_range(0, 12);
         if (w != 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic req_type make_req(logic [1:0] op, int size, int addr, bit is_null);
      req_type r;
      r.opcode = op;
      r.request_size = 12'(size);
      r.block_address = 20'(addr);
      r.address_is_null = is_null;
      return r;
   endfunction

   // Present one beat after a random gap and hold it until it is accepted. The caller is
   // always at a rising edge, so valid gets a single assignment per edge.
   task automatic send(input req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (r.opcode == OP_CLEAR) begin
         held_q.delete();
         epoch++;
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // A free of a block that was handed out, sometimes with a wrong size, sometimes kept for
   // a second free, and always with random low address bits that the block ignores.
   function automatic req_type free_held();
      held_block_type h;
      int k;
      int size;
      k = $urandom_range(0, held_q.size() - 1);
      h = held_q[k];
      if ($urandom_range(0, 9) != 0) held_q.delete(k);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 640) : h.size;
      return make_req(OP_FREE, size, {h.addr[19:4], 4'($urandom)}, 1'b0);
   endfunction

   function automatic req_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return make_req(OP_ALLOC, $urandom_range(1, 640), $urandom, 1'($urandom));
      if (pick < 45)
         return make_req(OP_ALLOC, $urandom_range(641, 4095), $urandom, 1'($urandom));
      if (pick < 48) return make_req(OP_ALLOC, 0, $urandom, 1'($urandom));
      if (pick < 83 && held_q.size() != 0) return free_held();
      if (pick < 88) return make_req(OP_FREE, $urandom_range(0, 4095), $urandom, 1'b1);
      if (pick < 90) return make_req(OP_FREE, 0, $urandom, 1'b0);
      if (pick < 92) return make_req(OP_FREE, $urandom_range(641, 4095), $urandom, 1'b0);
      if (pick < 95) return make_req(OP_IDLE, $urandom, $urandom, 1'($urandom));
      if (pick < 97) return make_req(OP_CLEAR, $urandom, $urandom, 1'($urandom));
      return make_req(OP_ALLOC, $urandom_range(1, 640), 0, 1'b0);
   endfunction

   initial begin
      localparam int ClassTop [14] = '{16, 32, 64, 96, 128, 160, 192, 224,
                                       256, 320, 384, 448, 512, 640};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: size edges, null and rejected requests, misaligned and double frees.
      // The first allocate that is served after reset carves chunk zero, so its block sits at address zero.
      send(make_req(OP_ALLOC, 0, 0, 1'b0));
      send(make_req(OP_ALLOC, 1, 20'hFFFFF, 1'b1));
      send(make_req(OP_ALLOC, 17, 0, 1'b0));
      send(make_req(OP_ALLOC, 641, 0, 1'b0));
      send(make_req(OP_ALLOC, 4095, 20'hFFFFF, 1'b1));
      send(make_req(OP_FREE, 16, 20'h0000F, 1'b0));
      send(make_req(OP_ALLOC, 16, 0, 1'b0));
      send(make_req(OP_FREE, 16, 0, 1'b0));
      send(make_req(OP_FREE, 16, 20'h00005, 1'b0));
      send(make_req(OP_ALLOC, 16, 0, 1'b0));
      send(make_req(OP_ALLOC, 16, 0, 1'b0));
      send(make_req(OP_FREE, 16, 20'hFFFFF, 1'b1));
      send(make_req(OP_FREE, 0, 20'hFFFFF, 1'b0));
      send(make_req(OP_FREE, 4095, 20'hFFFFF, 1'b0));
      send(make_req(OP_FREE, 641, 20'h00010, 1'b0));
      send(make_req(OP_IDLE, 4095, 20'hFFFFF, 1'b1));
      send(make_req(OP_IDLE, 0, 0, 1'b0));
      send(make_req(OP_CLEAR, 4095, 20'hFFFFF, 1'b1));
      send(make_req(OP_ALLOC, 640, 0, 1'b0));
      send(make_req(OP_CLEAR, 0, 0, 1'b0));

      // Hold off until every response is back before the pool is run dry.
      drain();

      // Take a chunk for every class, then keep allocating from the largest class until all
      // chunks are gone and the allocator reports an empty pool; a calm stretch comes first.
      calm = 1'b1;
      foreach (ClassTop[i]) send(make_req(OP_ALLOC, ClassTop[i], $urandom, 1'($urandom)));
      calm = 1'b0;
      for (int i = 0; i < 1290; i++) begin
         if (i % 400 == 399) calm = ~calm;
         send(make_req(OP_ALLOC, $urandom_range(513, 640), $urandom, 1'($urandom)));
      end
      calm = 1'b0;
      for (int i = 0; i < 40; i++) send(make_req(OP_ALLOC, $urandom_range(449, 512), 0, 1'b0));

      // Mixed traffic, with calm stretches now and then.
      for (int i = 0; i < 500; i++) begin
         if (i % 120 == 100) calm = 1'b1;
         if (i % 120 == 119) calm = 1'b0;
         send(random_item());
      end
      calm = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/scba_pkg.sv
design/scba_ram.sv
design/scba_front.sv
design/scba_back.sv
design/size_class_block_allocator_top.sv
tb/scba_checker.sv
tb/tb_size_class_block_allocator_top.sv
